[rtl/rch_pkg.sv]
// Shared types and constants for the RGB colour histogram with bounding box.
// Command and result transfer structs, opcodes and register indexes.
// No dependencies.
`default_nettype none

package rch_pkg;

  // Opcodes of the command transfer
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result kinds
  localparam logic RK_SUMMARY = 1'b0;
  localparam logic RK_READ    = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE     = 2'd2;

  // Register reset values
  localparam logic [7:0] STRIDE_RST    = 8'd10;
  localparam logic [7:0] ALPHA_THR_RST = 8'd125;
  localparam logic [7:0] WHITE_RST     = 8'd250;

  // Fixed field widths of the transfers
  localparam int BIN_IDX_W   = 15;
  localparam int BIN_COUNT_W = 24;
  localparam int BOX_W       = 5;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic                 last_pixel;
    logic [BIN_IDX_W-1:0] bin_index;
  } cmd_t;

  typedef struct packed {
    logic                   result_kind;
    logic [BIN_COUNT_W-1:0] bin_count;
    logic [BOX_W-1:0]       red_low;
    logic [BOX_W-1:0]       red_high;
    logic [BOX_W-1:0]       green_low;
    logic [BOX_W-1:0]       green_high;
    logic [BOX_W-1:0]       blue_low;
    logic [BOX_W-1:0]       blue_high;
    logic                   box_valid;
  } res_t;

  // Bounding box summary as reported, already zeroed when nothing was found
  typedef struct packed {
    logic [BOX_W-1:0] red_low;
    logic [BOX_W-1:0] red_high;
    logic [BOX_W-1:0] green_low;
    logic [BOX_W-1:0] green_high;
    logic [BOX_W-1:0] blue_low;
    logic [BOX_W-1:0] blue_high;
    logic             box_valid;
  } box_t;

endpackage

`default_nettype wire

[rtl/rch_bin_mem.sv]
// Histogram bin memory: one write port, one read port, registered read data.
// Generic storage; no package dependency.
`default_nettype none

module rch_bin_mem #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write and registered read; a read of the entry being written sees old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/rch_pixel_filter.sv]
// Pixel sampling, alpha and white rejection, channel cut and bounding box state.
// Holds the configuration registers. Depends on rch_pkg.
`default_nettype none

module rch_pixel_filter #(
  parameter int SIGNIFICANT_BITS = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              take_i,
  input  wire logic                              clear_i,
  input  wire rch_pkg::cmd_t                     cmd_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [rch_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [7:0]                        cfg_wdata_i,
  output logic                                   count_o,
  output logic      [3*SIGNIFICANT_BITS-1:0]     bin_o,
  output rch_pkg::box_t                          box_o
);

  import rch_pkg::*;

  localparam int SB = SIGNIFICANT_BITS;
  localparam logic [SB-1:0] CHAN_MAX = {SB{1'b1}};
  localparam int WIDE_W = (SB > BOX_W) ? SB : BOX_W;

  logic [7:0]    stride_q, alpha_thr_q, white_q;
  logic [7:0]    phase_q, phase_d;
  logic [SB-1:0] min_q [3];
  logic [SB-1:0] max_q [3];
  logic [SB-1:0] chan [3];
  logic          found_q;
  logic [7:0]    stride_eff;
  logic [8:0]    phase_inc;
  logic          pass;
  logic [WIDE_W-1:0] lo_w [3];
  logic [WIDE_W-1:0] hi_w [3];

  // Sampling phase and pixel acceptance
  always_comb begin
    stride_eff = (stride_q == 8'd0) ? 8'd1 : stride_q;
    phase_inc  = {1'b0, phase_q} + 9'd1;
    pass = (phase_q == 8'd0) && (cmd_i.alpha >= alpha_thr_q) &&
           !((cmd_i.red > white_q) && (cmd_i.green > white_q) && (cmd_i.blue > white_q));
    chan[0] = cmd_i.red[7 -: SB];
    chan[1] = cmd_i.green[7 -: SB];
    chan[2] = cmd_i.blue[7 -: SB];
    if (cmd_i.last_pixel || (phase_inc >= {1'b0, stride_eff})) begin
      phase_d = 8'd0;
    end else begin
      phase_d = phase_inc[7:0];
    end
  end

  assign count_o = take_i && pass;
  assign bin_o   = {chan[0], chan[1], chan[2]};

  // Configuration, phase and box registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q    <= STRIDE_RST;
      alpha_thr_q <= ALPHA_THR_RST;
      white_q     <= WHITE_RST;
      phase_q     <= 8'd0;
      found_q     <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        min_q[c] <= CHAN_MAX;
        max_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STRIDE:    stride_q    <= cfg_wdata_i;
          CFG_ALPHA_THR: alpha_thr_q <= cfg_wdata_i;
          CFG_WHITE:     white_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (clear_i) begin
        phase_q <= 8'd0;
        found_q <= 1'b0;
        for (int c = 0; c < 3; c++) begin
          min_q[c] <= CHAN_MAX;
          max_q[c] <= '0;
        end
      end else if (take_i) begin
        phase_q <= phase_d;
        if (pass) begin
          found_q <= 1'b1;
          for (int c = 0; c < 3; c++) begin
            if (chan[c] < min_q[c]) min_q[c] <= chan[c];
            if (chan[c] > max_q[c]) max_q[c] <= chan[c];
          end
        end
      end
    end
  end

  // Summary view, cut to the reported field width
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lo_w[c] = found_q ? WIDE_W'(min_q[c]) : '0;
      hi_w[c] = found_q ? WIDE_W'(max_q[c]) : '0;
    end
    box_o.red_low    = lo_w[0][BOX_W-1:0];
    box_o.red_high   = hi_w[0][BOX_W-1:0];
    box_o.green_low  = lo_w[1][BOX_W-1:0];
    box_o.green_high = hi_w[1][BOX_W-1:0];
    box_o.blue_low   = lo_w[2][BOX_W-1:0];
    box_o.blue_high  = hi_w[2][BOX_W-1:0];
    box_o.box_valid  = found_q;
  end

endmodule

`default_nettype wire

[rtl/rgb_color_histogram_with_bbox.sv]
// RGB colour histogram with bounding box. A result strobes in the cycle after its
// command transfer. One command per cycle while not busy; the bin read-modify-write
// overlaps the next command by forwarding. A clear holds busy while the bin memory
// is swept to zero, one entry a cycle; after reset the same sweep runs.
// The receiver cannot stall. Depends on rch_pkg, rch_bin_mem, rch_pixel_filter.
`default_nettype none

module rgb_color_histogram_with_bbox #(
  parameter int SIGNIFICANT_BITS = 5,
  parameter int COUNT_BITS       = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rch_pkg::cmd_t                 cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rch_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]                    cfg_wdata_i,
  output logic                               res_strobe_o,
  output rch_pkg::res_t                      res_o
);

  import rch_pkg::*;

  localparam int BIN_W  = 3 * SIGNIFICANT_BITS;
  localparam int WIDE_W = (BIN_W > BIN_IDX_W) ? BIN_W : BIN_IDX_W;
  localparam int CNT_WW = (COUNT_BITS > BIN_COUNT_W) ? COUNT_BITS : BIN_COUNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic wr;
    logic read_out;
    logic summary;
  } s2_ctl_t;

  logic                  accept, take, rd_op, clr;
  logic                  pix_count;
  logic [BIN_W-1:0]      pix_bin, rd_addr;
  logic [WIDE_W-1:0]     idx_wide;
  box_t                  box;
  logic                  mem_re, mem_we;
  logic [BIN_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;
  logic [COUNT_BITS-1:0] cur, inc;
  logic [CNT_WW-1:0]     cur_wide;
  s2_ctl_t               s2_q, s2_d;
  logic [BIN_W-1:0]      s2_addr_q;
  logic                  fwd_hit_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic                  clearing_q;
  logic [BIN_W-1:0]      clr_ptr_q;

  // Command transfer decode
  assign busy   = clearing_q;
  assign accept = start && !busy;
  assign take   = accept && (cmd_i.opcode == OP_PIXEL);
  assign rd_op  = accept && (cmd_i.opcode == OP_READ);
  assign clr    = accept && (cmd_i.opcode == OP_CLEAR);

  rch_pixel_filter #(
    .SIGNIFICANT_BITS(SIGNIFICANT_BITS)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .clear_i     (clr),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .count_o     (pix_count),
    .bin_o       (pix_bin),
    .box_o       (box)
  );

  // Read address: counted pixel bin or requested bin, masked to the bin count
  assign idx_wide = WIDE_W'(cmd_i.bin_index);
  assign rd_addr  = rd_op ? idx_wide[BIN_W-1:0] : pix_bin;
  assign mem_re   = pix_count || rd_op;

  // Second stage: current count with forwarding, saturating increment
  assign cur = fwd_hit_q ? fwd_data_q : mem_rdata;
  assign inc = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);

  // Write port shared by the clearing sweep and the increment
  assign mem_we    = clearing_q || s2_q.wr;
  assign mem_waddr = clearing_q ? clr_ptr_q : s2_addr_q;
  assign mem_wdata = clearing_q ? '0 : inc;

  rch_bin_mem #(
    .ADDR_W(BIN_W),
    .DATA_W(COUNT_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    s2_d.wr       = pix_count;
    s2_d.read_out = rd_op;
    s2_d.summary  = take && cmd_i.last_pixel;
  end

  // Pipeline control, forwarding and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q       <= '0;
      fwd_hit_q  <= 1'b0;
      clearing_q <= 1'b1;
      clr_ptr_q  <= '0;
    end else begin
      s2_q      <= s2_d;
      fwd_hit_q <= mem_re && s2_q.wr && (s2_addr_q == rd_addr);
      if (clr) begin
        clearing_q <= 1'b1;
        clr_ptr_q  <= '0;
      end else if (clearing_q) begin
        clr_ptr_q <= clr_ptr_q + BIN_W'(1);
        if (clr_ptr_q == {BIN_W{1'b1}}) clearing_q <= 1'b0;
      end
    end
  end

  // Payload registers of the second stage
  always_ff @(posedge clk_i) begin
    s2_addr_q  <= rd_addr;
    fwd_data_q <= inc;
  end

  // Result transfer
  assign cur_wide     = CNT_WW'(cur);
  assign res_strobe_o = s2_q.read_out || s2_q.summary;
  always_comb begin
    res_o             = '0;
    res_o.result_kind = s2_q.read_out ? RK_READ : RK_SUMMARY;
    if (s2_q.read_out) begin
      res_o.bin_count = cur_wide[BIN_COUNT_W-1:0];
    end else begin
      res_o.red_low    = box.red_low;
      res_o.red_high   = box.red_high;
      res_o.green_low  = box.green_low;
      res_o.green_high = box.green_high;
      res_o.blue_low   = box.blue_low;
      res_o.blue_high  = box.blue_high;
      res_o.box_valid  = box.box_valid;
    end
  end

endmodule

`default_nettype wire

[rtl/rch_checker.sv]
// Port-level checker for the colour histogram top level, with its bind.
// Depends on rch_pkg and rgb_color_histogram_with_bbox.
`default_nettype none

module rch_port_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire rch_pkg::cmd_t cmd_i,
  input wire logic          res_strobe_o,
  input wire rch_pkg::res_t res_o
);

  import rch_pkg::*;

  // A clear transfer starts the sweep, so busy follows
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.opcode == OP_CLEAR) |=> busy)
    else $error("clear not followed by busy");

  // No result is delivered during the clearing sweep
  a_no_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !res_strobe_o)
    else $error("result during clearing sweep");

  // A bin read answers in the next cycle with read data
  a_read_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.opcode == OP_READ)
    |=> res_strobe_o && (res_o.result_kind == RK_READ))
    else $error("bin read without read result");

  // The last pixel of an image answers in the next cycle with a summary
  a_summary_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.opcode == OP_PIXEL) && cmd_i.last_pixel
    |=> res_strobe_o && (res_o.result_kind == RK_SUMMARY))
    else $error("last pixel without summary");

  // Every result follows a command transfer in the previous cycle
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(start && !busy))
    else $error("result without a command transfer");

endmodule

bind rgb_color_histogram_with_bbox rch_port_checker u_rch_checker (.*);

`default_nettype wire

[test/rch_checker.sv]
// Scoreboard for the RGB colour histogram: watches the command, register and
// result channels, predicts every result and compares it with the block's.
// Depends on rch_pkg.
`default_nettype none

module rch_checker #(
  parameter int SIGNIFICANT_BITS = 5,
  parameter int COUNT_BITS       = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          busy_i,
  input  wire rch_pkg::cmd_t                 cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rch_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]                    cfg_wdata_i,
  input  wire logic                          res_strobe_i,
  input  wire rch_pkg::res_t                 res_i,
  output int                                 mismatch_count_o,
  output int                                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rch_pkg::*;

  localparam int NUM_BINS   = 1 << (3 * SIGNIFICANT_BITS);
  localparam int REPORT_MAX = 10;

  // Shadow of the block's state and registers
  logic [COUNT_BITS-1:0]       bin_tally [NUM_BINS];
  logic [SIGNIFICANT_BITS-1:0] chan_low  [3];
  logic [SIGNIFICANT_BITS-1:0] chan_high [3];
  bit                          pixel_seen;
  int                          sample_phase;
  logic [7:0]                  stride_reg;
  logic [7:0]                  alpha_reg;
  logic [7:0]                  white_reg;

  res_t expected_results[$];
  int   mismatches;

  // Empty the histogram and the box, restart sampling
  task automatic wipe();
    for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
    for (int ch = 0; ch < 3; ch++) begin
      chan_low[ch]  = '1;
      chan_high[ch] = '0;
    end
    pixel_seen   = 1'b0;
    sample_phase = 0;
  endtask

  // Stride sampling, alpha and white tests, then bin and box update
  task automatic count_pixel(input cmd_t c);
    int                              span;
    int                              nxt;
    bit                              kept;
    logic [SIGNIFICANT_BITS-1:0]     level [3];
    logic [3*SIGNIFICANT_BITS-1:0]   bin;
    span = (stride_reg == 8'd0) ? 1 : int'(stride_reg);
    kept = (sample_phase == 0);
    nxt  = sample_phase + 1;
    sample_phase = (nxt >= span) ? 0 : nxt;
    if (kept && c.alpha >= alpha_reg &&
        !(c.red > white_reg && c.green > white_reg && c.blue > white_reg)) begin
      level[0] = c.red[7 -: SIGNIFICANT_BITS];
      level[1] = c.green[7 -: SIGNIFICANT_BITS];
      level[2] = c.blue[7 -: SIGNIFICANT_BITS];
      for (int ch = 0; ch < 3; ch++) begin
        if (level[ch] > chan_high[ch]) chan_high[ch] = level[ch];
        if (level[ch] < chan_low[ch])  chan_low[ch]  = level[ch];
      end
      bin = {level[0], level[1], level[2]};
      // saturating counter
      if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 1'b1;
      pixel_seen = 1'b1;
    end
  endtask

  // Work out what one accepted command transfer leads to
  task automatic predict(input cmd_t c);
    res_t r;
    r = '0;
    case (c.opcode)
      OP_PIXEL: begin
        count_pixel(c);
        if (c.last_pixel) begin
          sample_phase  = 0;
          r.result_kind = RK_SUMMARY;
          if (pixel_seen) begin
            r.red_low    = chan_low[0];
            r.red_high   = chan_high[0];
            r.green_low  = chan_low[1];
            r.green_high = chan_high[1];
            r.blue_low   = chan_low[2];
            r.blue_high  = chan_high[2];
            r.box_valid  = 1'b1;
          end
          expected_results.insert(expected_results.size(), r);
        end
      end
      OP_READ: begin
        r.result_kind = RK_READ;
        r.bin_count   = bin_tally[int'(c.bin_index) & (NUM_BINS - 1)];
        expected_results.insert(expected_results.size(), r);
      end
      OP_CLEAR: wipe();
      default: ;
    endcase
  endtask

  // Result check first, then register writes, then the new command
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      stride_reg = STRIDE_RST;
      alpha_reg  = ALPHA_THR_RST;
      white_reg  = WHITE_RST;
      wipe();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (res_strobe_i) begin
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: result with nothing expected: kind=%0d count=%0d found=%0d",
                     $realtime, res_i.result_kind, res_i.bin_count, res_i.box_valid);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.result_kind !== res_i.result_kind || want.bin_count !== res_i.bin_count ||
              want.red_low !== res_i.red_low || want.red_high !== res_i.red_high ||
              want.green_low !== res_i.green_low || want.green_high !== res_i.green_high ||
              want.blue_low !== res_i.blue_low || want.blue_high !== res_i.blue_high ||
              want.box_valid !== res_i.box_valid) begin
            if (mismatches < REPORT_MAX) begin
              $display("%0t: mismatch exp kind=%0d count=%0d r=%0d..%0d g=%0d..%0d b=%0d..%0d f=%0d",
                       $realtime, want.result_kind, want.bin_count, want.red_low,
                       want.red_high, want.green_low, want.green_high, want.blue_low,
                       want.blue_high, want.box_valid);
              $display("%0t:          got kind=%0d count=%0d r=%0d..%0d g=%0d..%0d b=%0d..%0d f=%0d",
                       $realtime, res_i.result_kind, res_i.bin_count, res_i.red_low,
                       res_i.red_high, res_i.green_low, res_i.green_high, res_i.blue_low,
                       res_i.blue_high, res_i.box_valid);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STRIDE:    stride_reg = cfg_wdata_i;
          CFG_ALPHA_THR: alpha_reg  = cfg_wdata_i;
          CFG_WHITE:     white_reg  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) predict(cmd_i);
    end
    mismatch_count_o = mismatches;
    outstanding_o    = expected_results.size();
  end

endmodule

`default_nettype wire

[test/rgb_color_histogram_with_bbox_tb.sv]
// Top of the colour histogram testbench: clock, reset, command and register
// stimulus, and the verdict. Depends on rch_pkg, rch_checker and the block.
`default_nettype none

module rgb_color_histogram_with_bbox_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rch_pkg::*;

  localparam int         CLK_PERIOD    = 20;
  localparam int         LIMIT_CYCLES  = 2_500_000;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         END_WAIT      = 2000;
  localparam int         RANDOM_ITEMS  = 650;
  localparam int         PALETTE_N     = 6;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  cmd_t                 cmd_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_wdata_i;
  logic                 res_strobe_o;
  res_t                 res_o;
  int                   mismatch_count;
  int                   outstanding;

  // Stimulus bookkeeping
  int                   sent_items;
  bit                   no_idle;
  logic [7:0]           cur_alpha;
  logic [7:0]           cur_white;
  logic [23:0]          palette [PALETTE_N];
  logic [BIN_IDX_W-1:0] hit_bins[$];

  rgb_color_histogram_with_bbox u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  rch_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .cmd_i            (cmd_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .res_strobe_i     (res_strobe_o),
    .res_i            (res_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("rgb_color_histogram_with_bbox_tb: FAIL");
    $finish;
  end

  // Command builders; fields the opcode ignores are randomised
  function automatic cmd_t pixel_cmd(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a, logic last);
    cmd_t c;
    c.opcode     = OP_PIXEL;
    c.red        = r;
    c.green      = g;
    c.blue       = b;
    c.alpha      = a;
    c.last_pixel = last;
    c.bin_index  = BIN_IDX_W'($urandom);
    return c;
  endfunction

  function automatic cmd_t read_cmd(logic [BIN_IDX_W-1:0] idx);
    cmd_t c;
    c           = cmd_t'({$urandom, $urandom});
    c.opcode    = OP_READ;
    c.bin_index = idx;
    return c;
  endfunction

  function automatic cmd_t bare_cmd(logic [1:0] op);
    cmd_t c;
    c        = cmd_t'({$urandom, $urandom});
    c.opcode = op;
    return c;
  endfunction

  // Mostly bins that pixels have hit, sometimes anywhere
  function automatic logic [BIN_IDX_W-1:0] pick_bin();
    if (hit_bins.size() > 0 && $urandom_range(0, 9) < 6)
      return hit_bins[$urandom_range(0, hit_bins.size() - 1)];
    return BIN_IDX_W'($urandom);
  endfunction

  // Random pixel: palette colours, mostly opaque enough, a few whites
  task automatic next_pixel(input logic last, output cmd_t c);
    logic [23:0] rgb;
    logic [7:0]  a;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) rgb = palette[$urandom_range(0, PALETTE_N - 1)];
    else           rgb = 24'($urandom);
    if (pick >= 92 && cur_white < 8'd255)
      rgb = {8'($urandom_range(cur_white + 1, 255)), 8'($urandom_range(cur_white + 1, 255)),
             8'($urandom_range(cur_white + 1, 255))};
    if ($urandom_range(0, 99) < 85) a = 8'($urandom_range(cur_alpha, 255));
    else                            a = 8'($urandom);
    c = pixel_cmd(rgb[23:16], rgb[15:8], rgb[7:0], a, last);
    hit_bins.insert(hit_bins.size(), {c.red[7 -: BOX_W], c.green[7 -: BOX_W], c.blue[7 -: BOX_W]});
    if (hit_bins.size() > 64) void'(hit_bins.pop_front());
  endtask

  // One command transfer, after a random gap unless no_idle is set
  task automatic issue(input cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i = c;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    if (c.opcode != OP_UNUSED) sent_items++;
  endtask

  // Hold off until every result is in and the block is idle
  task automatic settle();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] a, input logic [7:0] w);
    write_reg(CFG_STRIDE, s);
    write_reg(CFG_ALPHA_THR, a);
    write_reg(CFG_WHITE, w);
    cur_alpha = a;
    cur_white = w;
  endtask

  initial begin
    cmd_t       c;
    logic [7:0] s;
    logic [7:0] a;
    logic [7:0] w;
    int         n;
    int         roll;
    int         images_left;
    int         clears_left;
    int         wait_cycles;
    bit         broken;

    start       = 1'b0;
    cmd_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    no_idle     = 1'b0;
    sent_items  = 0;
    cur_alpha   = ALPHA_THR_RST;
    cur_white   = WHITE_RST;
    clears_left = 6;
    images_left = 0;
    foreach (palette[k]) palette[k] = 24'($urandom);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty image, thresholds at their edges, white test, reads
    settle();
    set_config(8'd1, 8'd128, 8'd200);
    issue(pixel_cmd(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    issue(pixel_cmd(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
    issue(pixel_cmd(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    issue(pixel_cmd(8'd255, 8'd0, 8'd255, 8'd128, 1'b0));
    issue(pixel_cmd(8'd10, 8'd20, 8'd30, 8'd127, 1'b0));
    issue(pixel_cmd(8'd201, 8'd201, 8'd200, 8'd200, 1'b0));
    issue(pixel_cmd(8'd7, 8'd8, 8'd248, 8'd200, 1'b1));
    issue(read_cmd('0));
    issue(read_cmd({5'd31, 5'd0, 5'd31}));
    issue(read_cmd('1));
    issue(bare_cmd(OP_UNUSED));
    issue(read_cmd({5'd25, 5'd25, 5'd25}));
    // clear, then the histogram and box must be empty again
    issue(bare_cmd(OP_CLEAR));
    issue(read_cmd('0));
    issue(pixel_cmd(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));

    // zero stride keeps every pixel; no alpha floor, nothing counts as white
    settle();
    set_config(8'd0, 8'd0, 8'd255);
    issue(pixel_cmd(8'd255, 8'd255, 8'd255, 8'd0, 1'b0));
    issue(pixel_cmd(8'd255, 8'd255, 8'd255, 8'd0, 1'b1));
    issue(read_cmd('1));

    // stride lowered with the phase past the new stride
    settle();
    set_config(8'd5, 8'd0, 8'd255);
    issue(pixel_cmd(8'd40, 8'd80, 8'd120, 8'd9, 1'b0));
    issue(pixel_cmd(8'd160, 8'd200, 8'd240, 8'd9, 1'b0));
    issue(pixel_cmd(8'd1, 8'd2, 8'd3, 8'd9, 1'b0));
    settle();
    write_reg(CFG_STRIDE, 8'd2);
    issue(pixel_cmd(8'd96, 8'd96, 8'd96, 8'd9, 1'b0));
    issue(pixel_cmd(8'd32, 8'd64, 8'd8, 8'd9, 1'b1));

    // widest stride
    settle();
    set_config(8'd255, ALPHA_THR_RST, WHITE_RST);
    issue(pixel_cmd(8'd128, 8'd16, 8'd250, 8'd125, 1'b0));
    issue(pixel_cmd(8'd251, 8'd251, 8'd251, 8'd200, 1'b1));

    // Random images under changing settings
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (images_left == 0) begin
        settle();
        case ($urandom_range(0, 9))
          0:       s = 8'd0;
          1:       s = 8'd255;
          2, 3, 4: s = 8'd1;
          5, 6:    s = 8'($urandom_range(2, 4));
          default: s = 8'($urandom_range(5, 16));
        endcase
        case ($urandom_range(0, 7))
          0:       a = 8'd0;
          1:       a = 8'd255;
          default: a = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       w = 8'd0;
          1:       w = 8'd255;
          default: w = 8'($urandom_range(128, 255));
        endcase
        set_config(s, a, w);
        foreach (palette[k]) palette[k] = 24'($urandom);
        images_left = $urandom_range(1, 4);
      end
      images_left--;
      no_idle = ($urandom_range(0, 3) == 0);

      if (clears_left > 0 && $urandom_range(0, 11) == 0) begin
        issue(bare_cmd(OP_CLEAR));
        clears_left--;
      end

      // an image, sometimes empty, sometimes cut short without its last pixel
      n      = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      broken = ($urandom_range(0, 9) == 0);
      repeat (n) begin
        roll = $urandom_range(0, 99);
        if (roll < 8)       issue(read_cmd(pick_bin()));
        else if (roll < 11) issue(bare_cmd(OP_UNUSED));
        else begin
          next_pixel(1'b0, c);
          issue(c);
        end
      end
      if (!broken) begin
        next_pixel(1'b1, c);
        issue(c);
      end
      repeat ($urandom_range(0, 3)) issue(read_cmd(pick_bin()));
    end

    // Drain and verdict
    start       = 1'b0;
    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < END_WAIT) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    if (outstanding == 0) repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0)
      $display("rgb_color_histogram_with_bbox_tb: PASS");
    else
      $display("rgb_color_histogram_with_bbox_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
